// ===== rtl/scc_pkg.sv =====
// shared types and codes of the sector cache controller
package scc_pkg;

    localparam int DEF_ENTRIES      = 64;
    localparam int DEF_SECTOR_BYTES = 512;
    localparam int MAX_RESULTS      = 64;

    typedef enum logic [1:0] {
        CMD_READ  = 2'd0,
        CMD_WRITE = 2'd1,
        CMD_FLUSH = 2'd2,
        CMD_NONE  = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        KIND_WRITE_BACK = 2'd0,
        KIND_FILL       = 2'd1,
        KIND_GRANT      = 2'd2,
        KIND_FLUSH_DONE = 2'd3
    } kind_t;

    typedef enum logic [1:0] {
        SLOT_EMPTY = 2'd0,
        SLOT_CLEAN = 2'd1,
        SLOT_DIRTY = 2'd2,
        SLOT_SPARE = 2'd3
    } slot_st_t;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_LK_RD,
        ST_LK_CMP,
        ST_MISS,
        ST_WB_RD,
        ST_WB_EMIT,
        ST_FILL,
        ST_GRANT,
        ST_FL_CHK,
        ST_FL_RD,
        ST_FL_EMIT,
        ST_FL_DONE
    } back_state_t;

    typedef struct packed {
        cmd_t        command;
        logic [31:0] sector;
        logic [8:0]  offset;
        logic [9:0]  length;
    } req_t;

endpackage

// ===== rtl/scc_ram.sv =====
// generic single write port ram with registered read
module scc_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/scc_front.sv =====
// request intake: drops unknown commands and queues the rest for the back end
module scc_front (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_ready,
    input  scc_pkg::req_t in_req,
    output logic          q_valid,
    input  logic          q_pop,
    output scc_pkg::req_t q_req
);
    import scc_pkg::*;

    req_t       buf_reg [2];
    logic       wptr_reg, rptr_reg;
    logic [1:0] cnt_reg;
    logic       push;

    assign in_ready = (cnt_reg != 2'd2);
    assign push     = in_valid && in_ready && (in_req.command != CMD_NONE);
    assign q_valid  = (cnt_reg != 2'd0);
    assign q_req    = buf_reg[rptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            buf_reg[wptr_reg] <= in_req;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg <= 1'b0;
            rptr_reg <= 1'b0;
            cnt_reg  <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wptr_reg <= ~wptr_reg;
            end
            if (q_pop && q_valid)
            begin
                rptr_reg <= ~rptr_reg;
            end
            cnt_reg <= cnt_reg + 2'(push) - 2'(q_pop && q_valid);
        end
    end

endmodule

// ===== rtl/scc_back.sv =====
// request execution: tag scan, replacement, flush walk and result register
module scc_back #(
    parameter int ENTRIES      = 64,
    parameter int SECTOR_BYTES = 512
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          q_valid,
    output logic          q_pop,
    input  scc_pkg::req_t q_req,
    output logic          out_valid,
    input  logic          out_ready,
    output scc_pkg::kind_t out_kind,
    output logic [5:0]    out_slot,
    output logic [31:0]   out_sector,
    output logic [14:0]   out_addr,
    output logic [9:0]    out_count,
    output logic          out_last
);
    import scc_pkg::*;

    localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam logic [IW-1:0] LAST_IDX = IW'(ENTRIES - 1);
    localparam logic [9:0] SB_COUNT = 10'(SECTOR_BYTES);
    localparam logic [6:0] N_LIMIT = 7'(MAX_RESULTS - 1);

    back_state_t state_reg, state_next;
    req_t        req_reg, req_next;
    logic [IW-1:0] idx_reg, idx_next, slot_reg, slot_next;
    logic [IW-1:0] eslot_reg, eslot_next, victim_reg, victim_next;
    logic [IW-1:0] lslot_reg, lslot_next;
    logic [31:0] lsec_reg, lsec_next;
    logic        found_reg, found_next, have_reg, have_next;
    logic [6:0]  n_reg, n_next;

    logic          st_we;
    logic [IW-1:0] st_addr;
    slot_st_t      st_data;
    logic [IW-1:0] st_raddr;
    logic [1:0]    st_rdata;

    logic          ram_we;
    logic [IW-1:0] ram_raddr;
    logic [31:0]   ram_rdata;

    logic          ov_reg;
    kind_t         ok_reg;
    logic [5:0]    os_reg;
    logic [31:0]   osec_reg;
    logic [14:0]   oa_reg;
    logic [9:0]    oc_reg;
    logic          ol_reg;

    logic          out_free, emit, e_last;
    kind_t         e_kind;
    logic [IW-1:0] e_slot;
    logic [31:0]   e_sec;
    logic [14:0]   e_addr;
    logic [9:0]    e_count;
    logic [31:0]   rem32;
    logic [14:0]   g_addr;
    logic [9:0]    g_count;
    slot_st_t      st_idx;

    function automatic logic [14:0] base_of(input logic [IW-1:0] s);
        base_of = 15'(32'(s) * SECTOR_BYTES);
    endfunction

    assign out_free = !ov_reg || out_ready;
    assign st_idx   = slot_st_t'(st_rdata);
    assign ram_raddr = (state_reg == ST_WB_RD || state_reg == ST_WB_EMIT) ? slot_reg : idx_reg;
    assign ram_we   = (state_reg == ST_FILL) && out_free;

    // status is fetched ahead: the next scan index, or the victim when a miss is decided
    assign st_raddr = (state_next == ST_MISS) ? victim_reg : idx_next;

    scc_ram #(.WIDTH(32), .DEPTH(ENTRIES)) u_tags (
        .clk   (clk),
        .we    (ram_we),
        .waddr (slot_reg),
        .wdata (req_reg.sector),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    scc_ram #(.WIDTH(2), .DEPTH(ENTRIES)) u_status (
        .clk   (clk),
        .we    (st_we),
        .waddr (st_addr),
        .wdata (st_data),
        .raddr (st_raddr),
        .rdata (st_rdata)
    );

    // grant window, clamped to the sector end
    always_comb
    begin
        rem32 = SECTOR_BYTES - 32'(req_reg.offset);
        if (32'(req_reg.offset) >= SECTOR_BYTES)
        begin
            g_addr  = base_of(slot_reg);
            g_count = 10'd0;
        end
        else
        begin
            g_addr  = base_of(slot_reg) + 15'(req_reg.offset);
            g_count = (32'(req_reg.length) < rem32) ? req_reg.length : 10'(rem32);
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_CLEAR:
            begin
                if (idx_reg == LAST_IDX)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (q_valid)
                begin
                    state_next = (q_req.command == CMD_FLUSH) ? ST_FL_CHK : ST_LK_RD;
                end
            end
            ST_LK_RD:
            begin
                if (st_idx != SLOT_EMPTY)
                begin
                    state_next = ST_LK_CMP;
                end
                else if (idx_reg == LAST_IDX)
                begin
                    state_next = ST_MISS;
                end
            end
            ST_LK_CMP:
            begin
                if (ram_rdata == req_reg.sector)
                begin
                    state_next = ST_GRANT;
                end
                else
                begin
                    state_next = (idx_reg == LAST_IDX) ? ST_MISS : ST_LK_RD;
                end
            end
            ST_MISS:
            begin
                if (!found_reg && st_idx == SLOT_DIRTY)
                begin
                    state_next = ST_WB_RD;
                end
                else
                begin
                    state_next = ST_FILL;
                end
            end
            ST_WB_RD:   state_next = ST_WB_EMIT;
            ST_WB_EMIT: if (out_free) state_next = ST_FILL;
            ST_FILL:    if (out_free) state_next = ST_GRANT;
            ST_GRANT:   if (out_free) state_next = ST_IDLE;
            ST_FL_CHK:
            begin
                if (st_idx == SLOT_DIRTY && !(have_reg && n_reg >= N_LIMIT))
                begin
                    state_next = ST_FL_RD;
                end
                else if (idx_reg == LAST_IDX)
                begin
                    state_next = ST_FL_DONE;
                end
            end
            ST_FL_RD:   state_next = ST_FL_EMIT;
            ST_FL_EMIT:
            begin
                if (!have_reg || out_free)
                begin
                    state_next = (idx_reg == LAST_IDX) ? ST_FL_DONE : ST_FL_CHK;
                end
            end
            ST_FL_DONE: if (out_free) state_next = ST_IDLE;
            default:    state_next = ST_IDLE;
        endcase
    end

    // datapath and outputs
    always_comb
    begin
        req_next    = req_reg;
        idx_next    = idx_reg;
        slot_next   = slot_reg;
        eslot_next  = eslot_reg;
        victim_next = victim_reg;
        lslot_next  = lslot_reg;
        lsec_next   = lsec_reg;
        found_next  = found_reg;
        have_next   = have_reg;
        n_next      = n_reg;
        q_pop       = 1'b0;
        st_we       = 1'b0;
        st_addr     = idx_reg;
        st_data     = SLOT_EMPTY;
        emit        = 1'b0;
        e_kind      = KIND_GRANT;
        e_slot      = slot_reg;
        e_sec       = req_reg.sector;
        e_addr      = base_of(slot_reg);
        e_count     = SB_COUNT;
        e_last      = 1'b0;
        case (state_reg)
            ST_CLEAR:
            begin
                st_we = 1'b1;
                if (idx_reg != LAST_IDX)
                begin
                    idx_next = idx_reg + 1'b1;
                end
            end
            ST_IDLE:
            begin
                if (q_valid)
                begin
                    q_pop      = 1'b1;
                    req_next   = q_req;
                    idx_next   = '0;
                    found_next = 1'b0;
                    have_next  = 1'b0;
                    n_next     = 7'd0;
                end
            end
            ST_LK_RD:
            begin
                if (st_idx == SLOT_EMPTY)
                begin
                    if (!found_reg)
                    begin
                        found_next = 1'b1;
                        eslot_next = idx_reg;
                    end
                    if (idx_reg != LAST_IDX)
                    begin
                        idx_next = idx_reg + 1'b1;
                    end
                end
            end
            ST_LK_CMP:
            begin
                if (ram_rdata == req_reg.sector)
                begin
                    slot_next = idx_reg;
                end
                else if (idx_reg != LAST_IDX)
                begin
                    idx_next = idx_reg + 1'b1;
                end
            end
            ST_MISS:
            begin
                if (found_reg)
                begin
                    slot_next = eslot_reg;
                end
                else
                begin
                    slot_next   = victim_reg;
                    victim_next = (victim_reg == LAST_IDX) ? '0 : victim_reg + 1'b1;
                end
            end
            ST_WB_EMIT:
            begin
                emit   = out_free;
                e_kind = KIND_WRITE_BACK;
                e_sec  = ram_rdata;
            end
            ST_FILL:
            begin
                emit    = out_free;
                e_kind  = KIND_FILL;
                st_we   = out_free;
                st_addr = slot_reg;
                st_data = SLOT_CLEAN;
            end
            ST_GRANT:
            begin
                emit    = out_free;
                e_kind  = KIND_GRANT;
                e_addr  = g_addr;
                e_count = g_count;
                e_last  = 1'b1;
                st_we   = out_free && (req_reg.command == CMD_WRITE);
                st_addr = slot_reg;
                st_data = SLOT_DIRTY;
            end
            ST_FL_CHK:
            begin
                if (st_idx == SLOT_DIRTY)
                begin
                    // no room left for this one: it stays dirty
                    if (have_reg && n_reg >= N_LIMIT && idx_reg != LAST_IDX)
                    begin
                        idx_next = idx_reg + 1'b1;
                    end
                end
                else
                begin
                    st_we = 1'b1;
                    if (idx_reg != LAST_IDX)
                    begin
                        idx_next = idx_reg + 1'b1;
                    end
                end
            end
            ST_FL_EMIT:
            begin
                e_kind = KIND_WRITE_BACK;
                e_slot = lslot_reg;
                e_sec  = lsec_reg;
                e_addr = base_of(lslot_reg);
                if (!have_reg || out_free)
                begin
                    emit       = have_reg;
                    n_next     = n_reg + 7'(have_reg);
                    have_next  = 1'b1;
                    lslot_next = idx_reg;
                    lsec_next  = ram_rdata;
                    st_we      = 1'b1;
                    if (idx_reg != LAST_IDX)
                    begin
                        idx_next = idx_reg + 1'b1;
                    end
                end
            end
            ST_FL_DONE:
            begin
                emit    = out_free;
                e_kind  = KIND_FLUSH_DONE;
                e_last  = 1'b1;
                e_slot  = have_reg ? lslot_reg : '0;
                e_sec   = have_reg ? lsec_reg : 32'd0;
                e_addr  = have_reg ? base_of(lslot_reg) : 15'd0;
                e_count = have_reg ? SB_COUNT : 10'd0;
            end
            default:
            begin
                q_pop = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        req_reg   <= req_next;
        slot_reg  <= slot_next;
        eslot_reg <= eslot_next;
        lslot_reg <= lslot_next;
        lsec_reg  <= lsec_next;
        if (emit)
        begin
            ok_reg   <= e_kind;
            os_reg   <= 6'(e_slot);
            osec_reg <= e_sec;
            oa_reg   <= e_addr;
            oc_reg   <= e_count;
            ol_reg   <= e_last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_CLEAR;
            idx_reg    <= '0;
            victim_reg <= '0;
            found_reg  <= 1'b0;
            have_reg   <= 1'b0;
            n_reg      <= 7'd0;
            ov_reg     <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            idx_reg    <= idx_next;
            victim_reg <= victim_next;
            found_reg  <= found_next;
            have_reg   <= have_next;
            n_reg      <= n_next;
            if (emit)
            begin
                ov_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                ov_reg <= 1'b0;
            end
        end
    end

    assign out_valid  = ov_reg;
    assign out_kind   = ok_reg;
    assign out_slot   = os_reg;
    assign out_sector = osec_reg;
    assign out_addr   = oa_reg;
    assign out_count  = oc_reg;
    assign out_last   = ol_reg;

endmodule

// ===== rtl/sector_cache_controller_top.sv =====
// top level of the sector cache controller
// Tag and status controller for a fully associative write-back sector cache.
// After reset the slot status store is cleared slot by slot before the
// first request is taken. Requests enter a two-deep queue and are executed one
// at a time. A read or write scans the tag store one slot per step (a status
// read for an empty slot, a status read and a tag compare for an occupied
// one) and stops at a hit, then grants. A miss scans every slot, then fills
// and grants, with a write-back first when a dirty victim is replaced. A flush
// walks all slots, clearing a clean or empty one in the check step and reading
// out a dirty one for write-back up to the result limit, leaving later ones
// dirty. Output stalls lengthen the emitting steps. Results stream out
// through a register, one per cycle at most, each request's last with tlast.
module sector_cache_controller_top #(
    parameter int ENTRIES      = scc_pkg::DEF_ENTRIES,
    parameter int SECTOR_BYTES = scc_pkg::DEF_SECTOR_BYTES
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [55:0] s_axis_tdata,  // sector, offset, length
    input  logic [1:0]  s_axis_tuser,  // command
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [63:0] m_axis_tdata,  // slot, disk_sector, data_address, byte_count
    output logic [1:0]  m_axis_tuser,  // kind
    output logic        m_axis_tlast
);
    import scc_pkg::*;

    req_t       in_req, q_req;
    logic       q_valid, q_pop;
    kind_t      out_kind;
    logic [5:0] out_slot;
    logic [31:0] out_sector;
    logic [14:0] out_addr;
    logic [9:0] out_count;

    assign in_req.command = cmd_t'(s_axis_tuser);
    assign in_req.sector  = s_axis_tdata[31:0];
    assign in_req.offset  = s_axis_tdata[40:32];
    assign in_req.length  = s_axis_tdata[50:41];

    scc_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .in_req   (in_req),
        .q_valid  (q_valid),
        .q_pop    (q_pop),
        .q_req    (q_req)
    );

    scc_back #(.ENTRIES(ENTRIES), .SECTOR_BYTES(SECTOR_BYTES)) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .q_valid    (q_valid),
        .q_pop      (q_pop),
        .q_req      (q_req),
        .out_valid  (m_axis_tvalid),
        .out_ready  (m_axis_tready),
        .out_kind   (out_kind),
        .out_slot   (out_slot),
        .out_sector (out_sector),
        .out_addr   (out_addr),
        .out_count  (out_count),
        .out_last   (m_axis_tlast)
    );

    assign m_axis_tuser = out_kind;
    assign m_axis_tdata = {1'b0, out_count, out_addr, out_sector, out_slot};

    a_done_last: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tuser == KIND_FLUSH_DONE) |-> m_axis_tlast)
        else $error("flush done without tlast");

    a_grant_last: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tuser == KIND_GRANT) |-> m_axis_tlast)
        else $error("grant without tlast");

    a_mid_not_last: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && (m_axis_tuser == KIND_FILL || m_axis_tuser == KIND_WRITE_BACK))
        |-> !m_axis_tlast)
        else $error("fill or write back marked last");

endmodule

// ===== tb/sector_cache_controller_top_tb.sv =====
// self-checking testbench for the sector cache controller
`timescale 1ns / 100ps

module sector_cache_controller_top_tb;
    import scc_pkg::*;

    localparam int N_SLOTS   = 64;
    localparam int SEC_BYTES = 512;
    localparam int CYCLE_LIMIT = 1000000;

    typedef struct packed {
        kind_t       kind;
        logic [5:0]  slot;
        logic [31:0] disk_sector;
        logic [14:0] data_address;
        logic [9:0]  byte_count;
        logic        last;
    } cache_result_t;

    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [55:0] s_axis_tdata;   // sector, offset, length
    logic [1:0]  s_axis_tuser;   // command
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [63:0] m_axis_tdata;   // slot, disk_sector, data_address, byte_count
    logic [1:0]  m_axis_tuser;   // kind
    logic        m_axis_tlast;

    sector_cache_controller_top dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    // cache shadow
    logic [31:0]   tag_mirror [N_SLOTS];
    slot_st_t      status_mirror [N_SLOTS];
    logic [5:0]    victim_mirror;

    req_t          request_queue [$];
    cache_result_t expected_results [$];
    int            mismatch_count;
    int            cycle_count;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic cache_result_t make_result(kind_t k, int s, logic [31:0] sec,
                                                  int addr, int cnt, bit lst);
        cache_result_t r;
        r.kind         = k;
        r.slot         = s[5:0];
        r.disk_sector  = sec;
        r.data_address = addr[14:0];
        r.byte_count   = cnt[9:0];
        r.last         = lst;
        return r;
    endfunction

    task automatic predict_flush();
        int  issued;
        bit  have;
        int  lslot;
        logic [31:0] lsec;
        issued = 0;
        have   = 0;
        lslot  = 0;
        lsec   = '0;
        for (int i = 0; i < N_SLOTS; i++)
        begin
            if (status_mirror[i] == SLOT_DIRTY)
            begin
                if (have)
                begin
                    if (issued >= MAX_RESULTS - 1)
                        continue;   // no room left, slot stays dirty
                    expected_results.push_back(make_result(KIND_WRITE_BACK, lslot, lsec,
                        lslot * SEC_BYTES, SEC_BYTES, 1'b0));
                    issued++;
                end
                have  = 1;
                lslot = i;
                lsec  = tag_mirror[i];
            end
            status_mirror[i] = SLOT_EMPTY;
        end
        if (have)
            expected_results.push_back(make_result(KIND_FLUSH_DONE, lslot, lsec,
                lslot * SEC_BYTES, SEC_BYTES, 1'b1));
        else
            expected_results.push_back(make_result(KIND_FLUSH_DONE, 0, '0, 0, 0, 1'b1));
    endtask

    task automatic predict_access(req_t rq);
        int  slot;
        bit  hit;
        bit  found;
        int  addr;
        int  cnt;
        slot  = 0;
        hit   = 0;
        found = 0;
        for (int i = 0; i < N_SLOTS; i++)
            if (!hit && status_mirror[i] != SLOT_EMPTY && tag_mirror[i] == rq.sector)
            begin
                slot = i;
                hit  = 1;
            end
        if (!hit)
        begin
            for (int i = 0; i < N_SLOTS; i++)
                if (!found && status_mirror[i] == SLOT_EMPTY)
                begin
                    slot  = i;
                    found = 1;
                end
            if (!found)
            begin
                slot = victim_mirror;
                victim_mirror = victim_mirror + 6'd1;
                if (status_mirror[slot] == SLOT_DIRTY)
                    expected_results.push_back(make_result(KIND_WRITE_BACK, slot,
                        tag_mirror[slot], slot * SEC_BYTES, SEC_BYTES, 1'b0));
            end
            tag_mirror[slot]    = rq.sector;
            status_mirror[slot] = SLOT_CLEAN;
            expected_results.push_back(make_result(KIND_FILL, slot, rq.sector,
                slot * SEC_BYTES, SEC_BYTES, 1'b0));
        end
        if (rq.offset >= SEC_BYTES)
        begin
            addr = slot * SEC_BYTES;
            cnt  = 0;
        end
        else
        begin
            addr = slot * SEC_BYTES + rq.offset;
            cnt  = SEC_BYTES - rq.offset;
            if (rq.length < cnt)
                cnt = rq.length;
        end
        if (rq.command == CMD_WRITE)
            status_mirror[slot] = SLOT_DIRTY;
        expected_results.push_back(make_result(KIND_GRANT, slot, rq.sector, addr, cnt, 1'b1));
    endtask

    task automatic add_request(cmd_t c, logic [31:0] sec, logic [8:0] off, logic [9:0] len);
        req_t rq;
        rq.command = c;
        rq.sector  = sec;
        rq.offset  = off;
        rq.length  = len;
        request_queue.push_back(rq);
    endtask

    // driver
    int send_gap;
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata  <= '0;
            s_axis_tuser  <= CMD_READ;
            send_gap      <= 0;
        end
        else
        begin
            if (s_axis_tvalid && s_axis_tready)
            begin
                case (cmd_t'(s_axis_tuser))
                    CMD_READ, CMD_WRITE:
                        predict_access(req_t'{cmd_t'(s_axis_tuser), s_axis_tdata[31:0],
                            s_axis_tdata[40:32], s_axis_tdata[50:41]});
                    CMD_FLUSH:           predict_flush();
                    default:             ;
                endcase
            end
            if (!s_axis_tvalid || s_axis_tready)
            begin
                if (send_gap > 0)
                begin
                    s_axis_tvalid <= 1'b0;
                    send_gap      <= send_gap - 1;
                end
                else if (request_queue.size() > 0)
                begin
                    req_t rq;
                    rq = request_queue.pop_front();
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata  <= {5'd0, rq.length, rq.offset, rq.sector};
                    s_axis_tuser  <= rq.command;
                    send_gap      <= (($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 3));
                end
                else
                    s_axis_tvalid <= 1'b0;
            end
        end
    end

    // monitor and result checker
    int recv_gap;
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_axis_tready  <= 1'b0;
            recv_gap       <= 0;
            mismatch_count <= 0;
        end
        else
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                cache_result_t got;
                cache_result_t want;
                got = {kind_t'(m_axis_tuser), m_axis_tdata[5:0], m_axis_tdata[37:6],
                       m_axis_tdata[52:38], m_axis_tdata[62:53], m_axis_tlast};
                if (expected_results.size() == 0)
                begin
                    if (mismatch_count < 10)
                        $display("unexpected result: %p", got);
                    mismatch_count <= mismatch_count + 1;
                end
                else
                begin
                    want = expected_results.pop_front();
                    if (got !== want || m_axis_tdata[63] !== 1'b0)
                    begin
                        if (mismatch_count < 10)
                            $display("mismatch: expected %p, got %p", want, got);
                        mismatch_count <= mismatch_count + 1;
                    end
                end
            end
            if (recv_gap > 0)
            begin
                m_axis_tready <= 1'b0;
                recv_gap      <= recv_gap - 1;
            end
            else
            begin
                m_axis_tready <= 1'b1;
                if (m_axis_tvalid && m_axis_tready)
                    recv_gap <= (($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 3));
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("tb: failure");
            $finish;
        end
    end

    initial
    begin
        logic [31:0] pool [8];
        int          r;
        cycle_count   = 0;
        victim_mirror = '0;
        for (int i = 0; i < N_SLOTS; i++)
        begin
            status_mirror[i] = SLOT_EMPTY;
            tag_mirror[i]    = '0;
        end
        rst_n = 1'b0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        // directed: extremes, all commands, offset at the sector's last byte, idle flush, ignored command
        add_request(CMD_FLUSH, 32'h0, 9'd0, 10'd0);
        add_request(CMD_READ, 32'h0, 9'd0, 10'd0);
        add_request(CMD_WRITE, 32'hFFFF_FFFF, 9'd511, 10'd512);
        add_request(CMD_READ, 32'hFFFF_FFFF, 9'd0, 10'd1023);
        add_request(CMD_WRITE, 32'h5555_AAAA, 9'h155, 10'h2AA);
        add_request(CMD_READ, 32'hAAAA_5555, 9'h0AA, 10'h155);
        add_request(CMD_NONE, 32'h1234_5678, 9'd3, 10'd4);
        add_request(CMD_WRITE, 32'h0, 9'd100, 10'd1);
        add_request(CMD_FLUSH, 32'h0, 9'd0, 10'd0);
        add_request(CMD_READ, 32'h0, 9'd256, 10'd512);
        // fill every slot dirty and force victim write-backs, then a full flush
        for (int i = 0; i < 70; i++)
            add_request(CMD_WRITE, 32'h100 + i, 9'($urandom), 10'($urandom_range(0, 512)));
        add_request(CMD_FLUSH, 32'h0, 9'd0, 10'd0);

        // random: small sector pool for hits, occasional flushes and noise
        for (int i = 0; i < 8; i++)
            pool[i] = $urandom;
        for (int i = 0; i < 69; i++)
        begin
            r = $urandom_range(0, 99);
            if (r < 4)
                add_request(CMD_FLUSH, $urandom, 9'($urandom), 10'($urandom));
            else if (r < 6)
                add_request(CMD_NONE, $urandom, 9'($urandom), 10'($urandom));
            else
                add_request(cmd_t'($urandom_range(0, 1)),
                    (r < 60) ? pool[$urandom_range(0, 7)] : 32'($urandom_range(0, 90)),
                    9'($urandom), ($urandom_range(0, 3) == 0) ? 10'($urandom) :
                    10'($urandom_range(0, 512)));
        end

        wait (request_queue.size() == 0 && !(s_axis_tvalid));
        wait (expected_results.size() == 0);
        repeat (400) @(posedge clk);
        if (mismatch_count == 0 && expected_results.size() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
